FILE: design/mats_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the makespan-after-tail-sort block.
// No dependencies.
package mats_pkg;

  localparam int unsigned TIME_W = 16;
  localparam int unsigned COMP_W = 25;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT
  } cell_op_t;

  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] setup;
    logic [TIME_W-1:0] run;
  } cell_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    cell_op_t          op;
    logic [TIME_W-1:0] setup;
    logic [TIME_W-1:0] run;
  } cell_ctl_t;

  typedef struct packed {
    logic clear;
    logic acc;
  } scan_ctl_t;

endpackage

FILE: design/mats_cell.sv
`timescale 1ns / 1ps
// One cell of the sorted job chain: sorted insert and left shift for the scan.
// Depends on mats_pkg.
module mats_cell (
  input  logic               clk,
  input  logic               rst,
  input  mats_pkg::cell_ctl_t ctl,
  input  mats_pkg::cell_t    left,
  input  logic               left_keep,
  input  mats_pkg::cell_t    right,
  output mats_pkg::cell_t    q,
  output logic               keep
);

  // Cell keeps its job if it sorts ahead of (or ties with) the new one.
  assign keep = q.valid && (q.run >= ctl.run);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else begin
      unique case (ctl.op)
        mats_pkg::OP_INSERT: begin
          if (!keep) begin
            if (left_keep) begin
              q <= '{valid: 1'b1, setup: ctl.setup, run: ctl.run};
            end else begin
              q <= left;
            end
          end
        end
        mats_pkg::OP_SHIFT: begin
          q <= right;
        end
        default: begin
          q <= q;
        end
      endcase
    end
  end

endmodule

FILE: design/mats_scan.sv
`timescale 1ns / 1ps
// Scan accumulator: running setup sum and largest finish time, saturated out.
// Depends on mats_pkg.
module mats_scan #(
  parameter int unsigned ACC_W = 25
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mats_pkg::scan_ctl_t               ctl,
  input  mats_pkg::cell_t                   head,
  output logic [mats_pkg::COMP_W-1:0]       best_sat
);

  localparam int unsigned CMP_W = (ACC_W > mats_pkg::COMP_W) ? ACC_W : mats_pkg::COMP_W;

  logic [ACC_W-1:0] sum;
  logic [ACC_W-1:0] best;
  logic [ACC_W-1:0] sum_next;
  logic [ACC_W-1:0] finish;
  logic [CMP_W-1:0] best_ext;
  logic [CMP_W-1:0] sat_lim;

  assign sum_next = sum + ACC_W'(head.setup);
  assign finish   = sum_next + ACC_W'(head.run);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      sum  <= '0;
      best <= '0;
    end else if (ctl.acc) begin
      sum <= sum_next;
      if (finish > best) begin
        best <= finish;
      end
    end
  end

  assign best_ext = CMP_W'(best);
  assign sat_lim  = CMP_W'({mats_pkg::COMP_W{1'b1}});
  assign best_sat = (best_ext > sat_lim) ? {mats_pkg::COMP_W{1'b1}}
                                         : best_ext[mats_pkg::COMP_W-1:0];

endmodule

FILE: design/makespan_after_tail_sort.sv
`timescale 1ns / 1ps
// Top level: longest-run-first makespan over a batch of jobs.
// Depends on mats_pkg, mats_cell, mats_scan.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------------------
//  job in  | setup_time, run_time, batch_end         | taken when start && !busy
//  result  | completion_time, overflowed             | valid for one cycle on done
//
// Jobs are taken one per cycle when not busy; unless the chain is full, each goes
// straight into its sorted slot in a row of MAX_JOBS cells (all cells compare
// against the new run time at once and the ones behind the slot move down by one).
// The transaction that carries batch_end starts a scan: the chain shifts
// toward cell 0 one job per cycle into the accumulator, and busy stays high
// until cell 0 holds no job, then done pulses with the result. The shift leaves
// the chain empty, ready for the next batch.
// Reset (rst, synchronous) empties the chain and the overflow flag.
// The receiver cannot stall: done is a single-cycle strobe.
module makespan_after_tail_sort #(
  parameter int unsigned MAX_JOBS = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [mats_pkg::TIME_W-1:0]       setup_time,
  input  logic [mats_pkg::TIME_W-1:0]       run_time,
  input  logic                              batch_end,
  output logic                              done,
  output logic [mats_pkg::COMP_W-1:0]       completion_time,
  output logic                              overflowed
);

  // Sum of up to MAX_JOBS setups plus one run fits in this width.
  localparam int unsigned ACC_W = mats_pkg::TIME_W + 1 + $clog2(MAX_JOBS);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t                  state;
  logic                    ovf;
  logic                    accept;
  logic                    full;
  mats_pkg::cell_ctl_t     cell_ctl;
  mats_pkg::scan_ctl_t     scan_ctl;
  mats_pkg::cell_t         cq   [MAX_JOBS];
  logic                    keep [MAX_JOBS];
  logic [mats_pkg::COMP_W-1:0] best_sat;

  assign accept = start && !busy;
  assign full   = cq[MAX_JOBS-1].valid;

  // Cell broadcast: insert on an accepted job unless the chain is full,
  // shift toward the head while scanning.
  always_comb begin
    cell_ctl.setup = setup_time;
    cell_ctl.run   = run_time;
    if (state == ST_SCAN) begin
      cell_ctl.op = mats_pkg::OP_SHIFT;
    end else if (accept && !full) begin
      cell_ctl.op = mats_pkg::OP_INSERT;
    end else begin
      cell_ctl.op = mats_pkg::OP_HOLD;
    end
  end

  always_comb begin
    scan_ctl.acc   = (state == ST_SCAN) && cq[0].valid;
    scan_ctl.clear = (state == ST_SCAN) && !cq[0].valid;
  end

  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
    mats_pkg::cell_t left_q;
    mats_pkg::cell_t right_q;
    logic            left_k;

    if (i == 0) begin : g_head
      assign left_q = '0;
      assign left_k = 1'b1;
    end else begin : g_body
      assign left_q = cq[i-1];
      assign left_k = keep[i-1];
    end

    if (i == MAX_JOBS - 1) begin : g_tail
      assign right_q = '0;
    end else begin : g_inner
      assign right_q = cq[i+1];
    end

    mats_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (cell_ctl),
      .left      (left_q),
      .left_keep (left_k),
      .right     (right_q),
      .q         (cq[i]),
      .keep      (keep[i])
    );
  end

  mats_scan #(
    .ACC_W (ACC_W)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctl      (scan_ctl),
    .head     (cq[0]),
    .best_sat (best_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
      ovf   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            // A job arriving at a full chain is dropped, even the last one.
            if (full) begin
              ovf <= 1'b1;
            end
            if (batch_end) begin
              state <= ST_SCAN;
              busy  <= 1'b1;
            end
          end
        end
        ST_SCAN: begin
          if (!cq[0].valid) begin
            done            <= 1'b1;
            completion_time <= best_sat;
            overflowed      <= ovf;
            ovf             <= 1'b0;
            state           <= ST_IDLE;
            busy            <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule
